// ----- hdl/tesp_pkg.sv -----
// Shared types, constants and byte classifiers for the escape sequence parser.
`timescale 1ns / 1ps
package tesp_pkg;

    localparam int MaxParamsDefault        = 16;
    localparam int ParamBitsDefault        = 16;
    localparam int MaxIntermediatesDefault = 2;
    localparam int QueueDepth              = 2;

    localparam logic [7:0] ByteEsc = 8'h1B;
    localparam logic [7:0] ByteCsi = 8'h9B;
    localparam logic [7:0] ByteOsc = 8'h9D;
    localparam logic [7:0] ByteDcs = 8'h90;
    localparam logic [7:0] ByteSt  = 8'h9C;
    localparam logic [7:0] ByteDel = 8'h7F;
    localparam logic [7:0] ByteSep = 8'h3B;
    localparam logic [3:0] DecimalBase = 4'd10;

    typedef enum logic [3:0] {
        ST_GND, ST_ESC, ST_ESCI, ST_CSIE, ST_CSII, ST_CSIP, ST_CSIN,
        ST_DCSE, ST_DCSN, ST_DCSI, ST_DCSP, ST_DCSPT, ST_SPA, ST_OSC
    } state_t;

    // operation handed from the classifier to the executor
    typedef enum logic [3:0] {
        OP_NONE, OP_EXEC, OP_PRINT, OP_COLLECT, OP_PARAM, OP_ESCD, OP_CSID,
        OP_PUT, OP_OSCPUT
    } op_t;

    typedef enum logic [2:0] {
        ACT_EXEC     = 3'd0,
        ACT_PRINT    = 3'd1,
        ACT_ESCD     = 3'd2,
        ACT_CSID     = 3'd3,
        ACT_DCS_PUT  = 3'd4,
        ACT_OSC_PUT  = 3'd5,
        ACT_DCS_END  = 3'd6,
        ACT_OSC_END  = 3'd7
    } act_code_t;

    // executor phase: string end stream first, then the action itself
    typedef enum logic [1:0] { PH_END, PH_ACT } phase_t;

    // classified command between front and back
    typedef struct packed {
        logic [7:0] byte_value;
        op_t        op;
        logic       end_dcs;   // emit dcs end stream first
        logic       end_osc;   // emit osc end first
        logic       clear;     // clear collected context after the op
    } cmd_t;

    function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    function automatic logic is_c0(input logic [7:0] c);
        return (c <= 8'h17) || (c == 8'h19) || in_rng(c, 8'h1C, 8'h1F);
    endfunction

endpackage

// ----- hdl/tesp_stream_if.sv -----
// Valid/ready channel interfaces for input bytes and result items.
`timescale 1ns / 1ps
interface tesp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    modport source (output valid, output byte_in, input ready);
    modport sink (input valid, input byte_in, output ready);
endinterface

interface tesp_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [7:0]  byte_value;
    logic [1:0]  intermediate_count;
    logic [7:0]  first_intermediate;
    logic [7:0]  second_intermediate;
    logic [4:0]  param_count;
    logic [3:0]  param_index;
    logic [15:0] param_value;
    logic        overflow;
    logic        last;
    modport source (output valid, output action, output byte_value,
        output intermediate_count, output first_intermediate,
        output second_intermediate, output param_count, output param_index,
        output param_value, output overflow, output last, input ready);
    modport sink (input valid, input action, input byte_value,
        input intermediate_count, input first_intermediate,
        input second_intermediate, input param_count, input param_index,
        input param_value, input overflow, input last, output ready);
endinterface

// ----- hdl/tesp_front.sv -----
// Front end: parser state table, classifies each byte into a command.
`timescale 1ns / 1ps
module tesp_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [7:0]         in_byte,
    output logic               in_ready,
    output logic               cmd_valid,
    output tesp_pkg::cmd_t     cmd,
    input  logic               cmd_ready
);
    tesp_pkg::state_t state_reg, state_next;
    tesp_pkg::op_t    op;
    logic             any;

    assign in_ready  = cmd_ready;
    assign cmd_valid = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tesp_pkg::ST_GND;
        else if (in_valid && cmd_ready)
            state_reg <= state_next;
    end

    always_comb
    begin
        logic [7:0] c;
        logic       chg;
        c = in_byte;
        state_next = state_reg;
        op = tesp_pkg::OP_NONE;
        any = 1'b1;
        priority if (c == 8'h18 || c == 8'h1A || tesp_pkg::in_rng(c, 8'h80, 8'h8F) ||
                     tesp_pkg::in_rng(c, 8'h91, 8'h97) || c == 8'h99 || c == 8'h9A ||
                     c == tesp_pkg::ByteSt)
        begin
            op = tesp_pkg::OP_EXEC; state_next = tesp_pkg::ST_GND;
        end
        else if (c == tesp_pkg::ByteEsc) state_next = tesp_pkg::ST_ESC;
        else if (c == 8'h98 || c == 8'h9E || c == 8'h9F) state_next = tesp_pkg::ST_SPA;
        else if (c == tesp_pkg::ByteDcs) state_next = tesp_pkg::ST_DCSE;
        else if (c == tesp_pkg::ByteOsc) state_next = tesp_pkg::ST_OSC;
        else if (c == tesp_pkg::ByteCsi) state_next = tesp_pkg::ST_CSIE;
        else
        begin
            any = 1'b0;
            unique case (state_reg)
                tesp_pkg::ST_ESC:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_ESCI;
                    end
                    else if (c == 8'h5B) state_next = tesp_pkg::ST_CSIE;
                    else if (c == 8'h5D) state_next = tesp_pkg::ST_OSC;
                    else if (c == 8'h50) state_next = tesp_pkg::ST_DCSE;
                    else if (c == 8'h58 || c == 8'h5E || c == 8'h5F)
                        state_next = tesp_pkg::ST_SPA;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h7E))
                    begin
                        op = tesp_pkg::OP_ESCD; state_next = tesp_pkg::ST_GND;
                    end
                tesp_pkg::ST_ESCI:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F)) op = tesp_pkg::OP_COLLECT;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h7E))
                    begin
                        op = tesp_pkg::OP_ESCD; state_next = tesp_pkg::ST_GND;
                    end
                tesp_pkg::ST_CSIE:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_CSIN;
                    end
                    else if (c == 8'h3A) state_next = tesp_pkg::ST_CSII;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h39) || c == tesp_pkg::ByteSep)
                    begin
                        op = tesp_pkg::OP_PARAM; state_next = tesp_pkg::ST_CSIP;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h3C, 8'h3F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_CSIP;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E))
                    begin
                        op = tesp_pkg::OP_CSID; state_next = tesp_pkg::ST_GND;
                    end
                tesp_pkg::ST_CSII:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E)) state_next = tesp_pkg::ST_GND;
                tesp_pkg::ST_CSIP:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h39) || c == tesp_pkg::ByteSep)
                        op = tesp_pkg::OP_PARAM;
                    else if (c == 8'h3A || tesp_pkg::in_rng(c, 8'h3C, 8'h3F))
                        state_next = tesp_pkg::ST_CSII;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_CSIN;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E))
                    begin
                        op = tesp_pkg::OP_CSID; state_next = tesp_pkg::ST_GND;
                    end
                tesp_pkg::ST_CSIN:
                    if (tesp_pkg::is_c0(c)) op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F)) op = tesp_pkg::OP_COLLECT;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h3F)) state_next = tesp_pkg::ST_CSII;
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E))
                    begin
                        op = tesp_pkg::OP_CSID; state_next = tesp_pkg::ST_GND;
                    end
                tesp_pkg::ST_DCSE:
                    if (c == 8'h3A) state_next = tesp_pkg::ST_DCSI;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_DCSN;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h39) || c == tesp_pkg::ByteSep)
                    begin
                        op = tesp_pkg::OP_PARAM; state_next = tesp_pkg::ST_DCSP;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h3C, 8'h3F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_DCSP;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E)) state_next = tesp_pkg::ST_DCSPT;
                tesp_pkg::ST_DCSN:
                    if (tesp_pkg::in_rng(c, 8'h20, 8'h2F)) op = tesp_pkg::OP_COLLECT;
                    else if (tesp_pkg::in_rng(c, 8'h30, 8'h3F)) state_next = tesp_pkg::ST_DCSI;
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E)) state_next = tesp_pkg::ST_DCSPT;
                tesp_pkg::ST_DCSP:
                    if (tesp_pkg::in_rng(c, 8'h30, 8'h39) || c == tesp_pkg::ByteSep)
                        op = tesp_pkg::OP_PARAM;
                    else if (c == 8'h3A || tesp_pkg::in_rng(c, 8'h3C, 8'h3F))
                        state_next = tesp_pkg::ST_DCSI;
                    else if (tesp_pkg::in_rng(c, 8'h20, 8'h2F))
                    begin
                        op = tesp_pkg::OP_COLLECT; state_next = tesp_pkg::ST_DCSN;
                    end
                    else if (tesp_pkg::in_rng(c, 8'h40, 8'h7E)) state_next = tesp_pkg::ST_DCSPT;
                tesp_pkg::ST_DCSPT:
                    if (c <= 8'h7E) op = tesp_pkg::OP_PUT;
                tesp_pkg::ST_OSC:
                    if (tesp_pkg::in_rng(c, 8'h20, tesp_pkg::ByteDel)) op = tesp_pkg::OP_OSCPUT;
                tesp_pkg::ST_DCSI, tesp_pkg::ST_SPA: ;
                default:
                    if (tesp_pkg::is_c0(c) || tesp_pkg::in_rng(c, 8'h80, 8'h9C))
                        op = tesp_pkg::OP_EXEC;
                    else if (tesp_pkg::in_rng(c, 8'h20, tesp_pkg::ByteDel))
                        op = tesp_pkg::OP_PRINT;
            endcase
        end
        chg = any || (state_next != state_reg);
        cmd.byte_value = c;
        cmd.op         = op;
        cmd.end_dcs    = chg && (state_reg == tesp_pkg::ST_DCSPT);
        cmd.end_osc    = chg && (state_reg == tesp_pkg::ST_OSC);
        cmd.clear      = chg && (state_next == tesp_pkg::ST_ESC ||
                                 state_next == tesp_pkg::ST_CSIE);
    end
endmodule

// ----- hdl/tesp_queue.sv -----
// Small command FIFO between classifier and executor.
`timescale 1ns / 1ps
module tesp_queue #(
    parameter int DEPTH = tesp_pkg::QueueDepth
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    input  tesp_pkg::cmd_t wr_data,
    output logic           wr_ready,
    output logic           rd_valid,
    output tesp_pkg::cmd_t rd_data,
    input  logic           rd_ready
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    tesp_pkg::cmd_t      mem_reg [DEPTH];
    logic [AW-1:0]       wp_reg, rp_reg;
    logic [AW:0]         cnt_reg;
    logic                push, pop;

    assign wr_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH) && !pop) |=> cnt_reg == (AW+1)'(DEPTH))
        else $error("queue full lost entry");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0) |=> cnt_reg <= 1) else $error("queue underflow");
endmodule

// ----- hdl/tesp_back.sv -----
// Back end: holds parameters and intermediates, streams result items.
`timescale 1ns / 1ps
module tesp_back #(
    parameter int MAX_PARAMS        = tesp_pkg::MaxParamsDefault,
    parameter int PARAM_BITS        = tesp_pkg::ParamBitsDefault,
    parameter int MAX_INTERMEDIATES = tesp_pkg::MaxIntermediatesDefault
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  tesp_pkg::cmd_t cmd,
    output logic           cmd_ready,
    tesp_result_if.source  res
);
    localparam int PI = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam int PC = $clog2(MAX_PARAMS + 1);
    localparam int II = (MAX_INTERMEDIATES > 1) ? $clog2(MAX_INTERMEDIATES) : 1;
    localparam int IC = $clog2(MAX_INTERMEDIATES + 1);

    logic [PARAM_BITS-1:0] pval_reg [MAX_PARAMS];
    logic [PC-1:0]         ptot_reg;
    logic [7:0]            ibyte_reg [MAX_INTERMEDIATES];
    logic [IC-1:0]         itot_reg;
    logic                  ovf_reg, drop_reg;
    tesp_pkg::phase_t      ph_reg;
    logic [PC-1:0]         k_reg;

    // output register
    logic                  ov_reg;
    logic [2:0]            oact_reg;
    logic [7:0]            obyte_reg, oi1_reg, oi2_reg;
    logic [1:0]            oicnt_reg;
    logic [4:0]            opc_reg;
    logic [3:0]            oidx_reg;
    logic [15:0]           oval_reg;
    logic                  oovf_reg, olast_reg;

    logic                  can_emit;
    logic                  emit, ctx, stream, lastres, done;
    logic [2:0]            eact;
    logic                  has_act_out;
    logic [PI-1:0]         kidx;

    assign can_emit = !ov_reg || res.ready;
    assign kidx     = k_reg[PI-1:0];

    // does the op produce a result of its own
    always_comb
    begin
        has_act_out = 1'b1;
        eact = tesp_pkg::ACT_EXEC;
        unique case (cmd.op)
            tesp_pkg::OP_EXEC:   eact = tesp_pkg::ACT_EXEC;
            tesp_pkg::OP_PRINT:  eact = tesp_pkg::ACT_PRINT;
            tesp_pkg::OP_ESCD:   eact = tesp_pkg::ACT_ESCD;
            tesp_pkg::OP_CSID:   eact = tesp_pkg::ACT_CSID;
            tesp_pkg::OP_PUT:    eact = tesp_pkg::ACT_DCS_PUT;
            tesp_pkg::OP_OSCPUT: eact = tesp_pkg::ACT_OSC_PUT;
            default:             has_act_out = 1'b0;
        endcase
    end

    // one result per cycle while the output is not stalled: end stream phase, then action phase
    always_comb
    begin
        emit = 1'b0; ctx = 1'b0; stream = 1'b0; lastres = 1'b0; done = 1'b0;
        if (cmd_valid && can_emit)
        begin
            if (ph_reg == tesp_pkg::PH_END && (cmd.end_dcs || cmd.end_osc))
            begin
                emit   = 1'b1;
                ctx    = cmd.end_dcs;
                stream = cmd.end_dcs;
                if (!cmd.end_dcs || ptot_reg == '0 || k_reg == ptot_reg - 1'b1)
                begin
                    lastres = !has_act_out;
                    done    = !has_act_out;
                end
            end
            else
            begin
                emit   = has_act_out;
                ctx    = (cmd.op == tesp_pkg::OP_ESCD) || (cmd.op == tesp_pkg::OP_CSID);
                stream = (cmd.op == tesp_pkg::OP_CSID);
                if (!stream || ptot_reg == '0 || k_reg == ptot_reg - 1'b1)
                begin
                    lastres = 1'b1;
                    done    = 1'b1;
                end
            end
        end
    end

    assign cmd_ready = done;

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            oact_reg  <= (ph_reg == tesp_pkg::PH_END && (cmd.end_dcs || cmd.end_osc))
                         ? (cmd.end_dcs ? tesp_pkg::ACT_DCS_END : tesp_pkg::ACT_OSC_END)
                         : eact;
            obyte_reg <= cmd.byte_value;
            oicnt_reg <= ctx ? ((itot_reg > IC'(2)) ? 2'd2 : 2'(itot_reg)) : 2'd0;
            oi1_reg   <= (ctx && itot_reg >= IC'(1)) ? ibyte_reg[0] : 8'd0;
            oi2_reg   <= (ctx && MAX_INTERMEDIATES >= 2 && itot_reg >= IC'(2))
                         ? ibyte_reg[II'(1 % MAX_INTERMEDIATES)] : 8'd0;
            opc_reg   <= ctx ? 5'(ptot_reg) : 5'd0;
            oidx_reg  <= (stream && ptot_reg != '0) ? 4'(k_reg) : 4'd0;
            oval_reg  <= (stream && ptot_reg != '0) ? 16'(pval_reg[kidx]) : 16'd0;
            oovf_reg  <= ctx ? ovf_reg : 1'b0;
            olast_reg <= lastres;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            ph_reg   <= tesp_pkg::PH_END;
            k_reg    <= '0;
            ptot_reg <= '0;
            itot_reg <= '0;
            ovf_reg  <= 1'b0;
            drop_reg <= 1'b0;
            for (int i = 0; i < MAX_PARAMS; i++)
                pval_reg[i] <= '0;
            for (int i = 0; i < MAX_INTERMEDIATES; i++)
                ibyte_reg[i] <= '0;
        end
        else
        begin
            if (emit)
                ov_reg <= 1'b1;
            else if (res.ready)
                ov_reg <= 1'b0;

            if (done)
            begin
                ph_reg <= tesp_pkg::PH_END;
                k_reg  <= '0;
            end
            else if (emit)
            begin
                if (ph_reg == tesp_pkg::PH_END && stream && !(ptot_reg == '0 ||
                    k_reg == ptot_reg - 1'b1))
                    k_reg <= k_reg + 1'b1;
                else if (ph_reg == tesp_pkg::PH_END)
                begin
                    ph_reg <= tesp_pkg::PH_ACT;
                    k_reg  <= '0;
                end
                else
                    k_reg <= k_reg + 1'b1;
            end

            if (done)
            begin
                if (cmd.op == tesp_pkg::OP_COLLECT)
                begin
                    if (itot_reg < IC'(MAX_INTERMEDIATES))
                    begin
                        ibyte_reg[itot_reg[II-1:0]] <= cmd.byte_value;
                        itot_reg <= itot_reg + 1'b1;
                    end
                    else
                        ovf_reg <= 1'b1;
                end
                else if (cmd.op == tesp_pkg::OP_PARAM)
                begin
                    if (cmd.byte_value == tesp_pkg::ByteSep)
                    begin
                        if (ptot_reg == '0)
                        begin
                            pval_reg[0] <= '0;
                            if (MAX_PARAMS > 1)
                            begin
                                pval_reg[PI'(1 % MAX_PARAMS)] <= '0;
                                ptot_reg <= PC'(2);
                            end
                            else
                            begin
                                ptot_reg <= PC'(1);
                                ovf_reg  <= 1'b1;
                                drop_reg <= 1'b1;
                            end
                        end
                        else if (ptot_reg < PC'(MAX_PARAMS))
                        begin
                            pval_reg[ptot_reg[PI-1:0]] <= '0;
                            ptot_reg <= ptot_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg  <= 1'b1;
                            drop_reg <= 1'b1;
                        end
                    end
                    else if (!drop_reg)
                    begin
                        logic [PI-1:0]          pi;
                        logic [PARAM_BITS+3:0]  v;
                        pi = (ptot_reg == '0) ? '0 : PI'(ptot_reg - 1'b1);
                        v  = ((ptot_reg == '0) ? '0 :
                              {4'd0, pval_reg[pi]} * (PARAM_BITS+4)'(tesp_pkg::DecimalBase))
                             + (PARAM_BITS+4)'(cmd.byte_value[3:0]);
                        if (ptot_reg == '0)
                            ptot_reg <= PC'(1);
                        if (v[PARAM_BITS+3:PARAM_BITS] != 4'd0)
                        begin
                            pval_reg[pi] <= '1;
                            ovf_reg      <= 1'b1;
                        end
                        else
                            pval_reg[pi] <= v[PARAM_BITS-1:0];
                    end
                end
                if (cmd.clear)
                begin
                    for (int i = 0; i < MAX_PARAMS; i++)
                        pval_reg[i] <= '0;
                    for (int i = 0; i < MAX_INTERMEDIATES; i++)
                        ibyte_reg[i] <= '0;
                    ptot_reg <= '0;
                    itot_reg <= '0;
                    ovf_reg  <= 1'b0;
                    drop_reg <= 1'b0;
                end
            end
        end
    end

    assign res.valid               = ov_reg;
    assign res.action              = oact_reg;
    assign res.byte_value          = obyte_reg;
    assign res.intermediate_count  = oicnt_reg;
    assign res.first_intermediate  = oi1_reg;
    assign res.second_intermediate = oi2_reg;
    assign res.param_count         = opc_reg;
    assign res.param_index         = oidx_reg;
    assign res.param_value         = oval_reg;
    assign res.overflow            = oovf_reg;
    assign res.last                = olast_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !res.ready) |=> $stable(oact_reg) && $stable(oidx_reg))
        else $error("result changed while stalled");
    a_ptot: assert property (@(posedge clk) disable iff (!rst_n)
        ptot_reg <= PC'(MAX_PARAMS)) else $error("param count exceeds storage");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        drop_reg |-> ovf_reg) else $error("drop without overflow");
endmodule

// ----- hdl/terminal_escape_sequence_parser_core.sv -----
// Top level of the terminal escape sequence parser.
`timescale 1ns / 1ps
// Channel    Dir  Payload                                  Transaction
// in_ch      in   byte_in[7:0]                             valid & ready
// out_ch     out  action, byte_value, intermediates,       valid & ready
//                 param_count/index/value, overflow, last
//
// Front classifies one byte per cycle while the queue has room and pushes a
// command into a 2-entry queue; the back end executes it, emitting one result
// per cycle while out_ch is not stalled. CSI dispatch and DCS end stream
// one result per parameter, up to MAX_PARAMS; then the command is popped.
// rst_n clears parser state, collected context, queue and output valid.
// A stalled output holds; the queue then fills and in_ch.ready drops.
module terminal_escape_sequence_parser_core #(
    parameter int MAX_PARAMS        = tesp_pkg::MaxParamsDefault,
    parameter int PARAM_BITS        = tesp_pkg::ParamBitsDefault,
    parameter int MAX_INTERMEDIATES = tesp_pkg::MaxIntermediatesDefault
) (
    input  logic         clk,
    input  logic         rst_n,
    tesp_byte_if.sink    in_ch,
    tesp_result_if.source out_ch
);
    tesp_pkg::cmd_t f_cmd, b_cmd;
    logic           f_valid, f_ready, b_valid, b_ready;

    tesp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_byte   (in_ch.byte_in),
        .in_ready  (in_ch.ready),
        .cmd_valid (f_valid),
        .cmd       (f_cmd),
        .cmd_ready (f_ready)
    );

    tesp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_data  (f_cmd),
        .wr_ready (f_ready),
        .rd_valid (b_valid),
        .rd_data  (b_cmd),
        .rd_ready (b_ready)
    );

    tesp_back #(
        .MAX_PARAMS        (MAX_PARAMS),
        .PARAM_BITS        (PARAM_BITS),
        .MAX_INTERMEDIATES (MAX_INTERMEDIATES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (b_valid),
        .cmd       (b_cmd),
        .cmd_ready (b_ready),
        .res       (out_ch)
    );
endmodule
